// ----- rtl/fbce_pkg.sv -----
package fbce_pkg;

   // table geometry
   localparam int SUBKEY_WORDS   = 18;
   localparam int BOX_ENTRIES    = 256;
   localparam int BOX_COUNT      = 4;

   // each table is split into an even bank and an odd bank so that a word pair
   // can be read together
   localparam int KEY_BANK_DEPTH = SUBKEY_WORDS / 2;
   localparam int KEY_ADDR_W     = $clog2(KEY_BANK_DEPTH);
   localparam int BOX_BANK_DEPTH = BOX_ENTRIES / 2;
   localparam int BOX_ADDR_W     = $clog2(BOX_BANK_DEPTH);
   localparam int BOX_INDEX_W    = $clog2(BOX_ENTRIES);

   // field widths
   localparam int MODE_W  = 3;
   localparam int INDEX_W = 11;
   localparam int WORD_W  = 32;
   localparam int BLOCK_W = 64;
   localparam int ROUND_W = 5;

   // wide round function index mixing
   localparam logic [BLOCK_W-1:0] IDX_MASK64 = 64'h007F_007F_007F_007F;
   localparam int                 MIX_SHIFT  = 24;

   // round_end limits
   localparam logic [ROUND_W-1:0] ROUND_END_MIN = 5'd4;
   localparam logic [ROUND_W-1:0] ROUND_END_MAX = 5'd17;

   // item modes
   localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ENC64  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DEC64  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ENC128 = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DEC128 = 3'd4;

   typedef logic [MODE_W-1:0]  mode_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [BLOCK_W-1:0] block_type;

endpackage

// ----- rtl/fbce_if.sv -----
// request channel: load words and cipher blocks
interface fbce_req_if;
   import fbce_pkg::*;

   logic      valid;
   logic      ready;
   mode_type  mode;
   index_type table_index;
   word_type  table_word;
   block_type block_low;
   block_type block_high;

   modport source (
      output valid, mode, table_index, table_word, block_low, block_high,
      input  ready
   );
   modport sink (
      input  valid, mode, table_index, table_word, block_low, block_high,
      output ready
   );
endinterface

// response channel: one beat per cipher block
interface fbce_rsp_if;
   import fbce_pkg::*;

   logic      valid;
   logic      ready;
   block_type out_low;
   block_type out_high;

   modport source (
      output valid, out_low, out_high,
      input  ready
   );
   modport sink (
      input  valid, out_low, out_high,
      output ready
   );
endinterface

// ----- rtl/feistel_block_cipher_engine_core.sv -----
// Feistel block cipher engine, one round per cycle from banked table memories.
// Load beat: written at the accepting edge; back to back loads every cycle while idle.
// Cipher beat: steps START, ROUND and WHITE over a span of R = round_end (R/2 in 128-bit mode);
//   the result is registered from WHITE, which holds while one waits; requests wait for idle.
// The box read -> round function -> next box address loop sets the one-round-per-cycle pace.
// Reset (synchronous, active high) clears control and sets round_end to 17; tables keep contents.
module feistel_block_cipher_engine_core (
   input  logic                         clock,
   input  logic                         reset,
   fbce_req_if.sink                     req_ch,
   fbce_rsp_if.source                   rsp_ch,
   input  logic                         csr_we,
   input  logic [fbce_pkg::ROUND_W-1:0] csr_wdata
);
   import fbce_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_ROUND = 2'd2;
   localparam logic [1:0] ST_WHITE = 2'd3;

   // control and datapath registers
   logic [1:0]         state_ff, state_in;
   logic [ROUND_W-1:0] step_ff, step_in;
   logic [ROUND_W-1:0] span_ff, span_in;
   logic               dec_ff, dec_in;
   logic               wide_ff, wide_in;
   logic [ROUND_W-1:0] round_end_ff, round_end_in;
   block_type          l_ff, l_in;
   block_type          r_ff, r_in;
   logic               rsp_valid_ff, rsp_valid_in;
   block_type          out_low_ff, out_low_in;
   block_type          out_high_ff, out_high_in;

   // request decode
   logic               accept;
   logic               acc_cipher;
   logic               acc_wide;
   logic               acc_dec;
   logic [ROUND_W-1:0] acc_span;
   logic               out_free;

   // subkey memory access
   word_type             key_even_mem [KEY_BANK_DEPTH];
   word_type             key_odd_mem  [KEY_BANK_DEPTH];
   word_type             key_even_rd_ff;
   word_type             key_odd_rd_ff;
   logic                 key_sel_ff, key_sel_in;
   logic                 key_we;
   logic [ROUND_W-1:0]   key_step;
   logic [ROUND_W-1:0]   key_idx;
   logic [ROUND_W-1:0]   cur_span;
   logic                 cur_dec;
   logic                 cur_wide;
   logic [KEY_ADDR_W-1:0] key_addr;
   block_type            kval;

   // box memory access
   index_type             box_off;
   logic [BOX_COUNT-1:0]  box_we;
   logic [BOX_ADDR_W-1:0] box_addr [BOX_COUNT];
   logic                  box_sel_in [BOX_COUNT];
   block_type             box_val [BOX_COUNT];

   // round function
   block_type f_raw;
   block_type f_val;
   block_type t_val;
   block_type x_val;
   block_type m_val;
   block_type r_fin;
   logic      last_step;

   assign accept     = req_ch.valid && req_ch.ready;
   assign acc_cipher = accept && (req_ch.mode == MODE_ENC64 || req_ch.mode == MODE_DEC64 ||
                                  req_ch.mode == MODE_ENC128 || req_ch.mode == MODE_DEC128);
   assign acc_wide   = (req_ch.mode == MODE_ENC128) || (req_ch.mode == MODE_DEC128);
   assign acc_dec    = (req_ch.mode == MODE_DEC64) || (req_ch.mode == MODE_DEC128);
   assign acc_span   = acc_wide ? (round_end_ff >> 1) : round_end_ff;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_low  = out_low_ff;
   assign rsp_ch.out_high = out_high_ff;

   // config register, saturated into range
   always_comb begin
      round_end_in = round_end_ff;
      if (csr_we) begin
         if (csr_wdata < ROUND_END_MIN) begin
            round_end_in = ROUND_END_MIN;
         end else if (csr_wdata > ROUND_END_MAX) begin
            round_end_in = ROUND_END_MAX;
         end else begin
            round_end_in = csr_wdata;
         end
      end
   end

   // load decode
   assign key_we  = accept && (req_ch.mode == MODE_LOAD) &&
                    (req_ch.table_index < INDEX_W'(SUBKEY_WORDS));
   assign box_off = req_ch.table_index - INDEX_W'(SUBKEY_WORDS);
   always_comb begin
      box_we = '0;
      if (accept && (req_ch.mode == MODE_LOAD) &&
          (req_ch.table_index >= INDEX_W'(SUBKEY_WORDS)) &&
          (req_ch.table_index < INDEX_W'(SUBKEY_WORDS + BOX_COUNT * BOX_ENTRIES))) begin
         box_we[box_off[BOX_INDEX_W +: 2]] = 1'b1;
      end
   end

   // key step schedule: rounds, then the two whitening steps
   assign cur_span = (state_ff == ST_IDLE) ? acc_span : span_ff;
   assign cur_dec  = (state_ff == ST_IDLE) ? acc_dec  : dec_ff;
   assign cur_wide = (state_ff == ST_IDLE) ? acc_wide : wide_ff;
   always_comb begin
      case (state_ff)
         ST_IDLE:  key_step = '0;
         ST_WHITE: key_step = step_ff;
         default:  key_step = step_ff + ROUND_W'(1);
      endcase
   end
   assign key_idx    = cur_dec ? (cur_span - key_step) : key_step;
   assign key_addr   = cur_wide ? key_idx[KEY_ADDR_W-1:0] : key_idx[KEY_ADDR_W:1];
   assign key_sel_in = key_idx[0];

   // subkey banks: one write, one registered read each
   always_ff @(posedge clock) begin
      if (key_we && !req_ch.table_index[0]) begin
         key_even_mem[req_ch.table_index[KEY_ADDR_W:1]] <= req_ch.table_word;
      end
      if (key_we && req_ch.table_index[0]) begin
         key_odd_mem[req_ch.table_index[KEY_ADDR_W:1]] <= req_ch.table_word;
      end
      key_even_rd_ff <= key_even_mem[key_addr];
      key_odd_rd_ff  <= key_odd_mem[key_addr];
      key_sel_ff     <= key_sel_in;
   end

   assign kval = wide_ff ? {key_odd_rd_ff, key_even_rd_ff}
                         : {{WORD_W{1'b0}}, (key_sel_ff ? key_odd_rd_ff : key_even_rd_ff)};

   // box banks
   for (genvar j = 0; j < BOX_COUNT; j++) begin : g_box
      word_type even_mem [BOX_BANK_DEPTH];
      word_type odd_mem  [BOX_BANK_DEPTH];
      word_type even_rd_ff;
      word_type odd_rd_ff;
      logic     sel_ff;

      always_ff @(posedge clock) begin
         if (box_we[j] && !box_off[0]) begin
            even_mem[box_off[BOX_ADDR_W:1]] <= req_ch.table_word;
         end
         if (box_we[j] && box_off[0]) begin
            odd_mem[box_off[BOX_ADDR_W:1]] <= req_ch.table_word;
         end
         even_rd_ff <= even_mem[box_addr[j]];
         odd_rd_ff  <= odd_mem[box_addr[j]];
         sel_ff     <= box_sel_in[j];
      end

      assign box_val[j] = wide_ff ? {odd_rd_ff, even_rd_ff}
                                  : {{WORD_W{1'b0}}, (sel_ff ? odd_rd_ff : even_rd_ff)};
   end

   // round function on the box words read last cycle
   assign f_raw = ((box_val[0] + box_val[1]) ^ box_val[2]) + box_val[3];
   assign f_val = wide_ff ? f_raw : {{WORD_W{1'b0}}, f_raw[WORD_W-1:0]};
   assign t_val = l_ff ^ f_val;

   // next right half after key mix; it addresses the boxes
   assign x_val = ((state_ff == ST_START) ? r_ff : t_val) ^ kval;
   assign m_val = ((x_val >> MIX_SHIFT) ^ x_val) & IDX_MASK64;
   always_comb begin
      for (int j = 0; j < BOX_COUNT; j++) begin
         box_addr[j]   = wide_ff ? m_val[16*j +: BOX_ADDR_W] : x_val[8*j+1 +: BOX_ADDR_W];
         box_sel_in[j] = x_val[8*j];
      end
   end

   assign last_step = (step_ff == span_ff - ROUND_W'(1));
   assign r_fin     = r_ff ^ kval;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      span_in      = span_ff;
      dec_in       = dec_ff;
      wide_in      = wide_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      out_low_in   = out_low_ff;
      out_high_in  = out_high_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      case (state_ff)
         ST_IDLE: begin
            if (acc_cipher) begin
               state_in = ST_START;
               step_in  = '0;
               span_in  = acc_span;
               dec_in   = acc_dec;
               wide_in  = acc_wide;
               if (acc_wide) begin
                  l_in = req_ch.block_high;
                  r_in = req_ch.block_low;
               end else begin
                  l_in = {{WORD_W{1'b0}}, req_ch.block_low[BLOCK_W-1:WORD_W]};
                  r_in = {{WORD_W{1'b0}}, req_ch.block_low[WORD_W-1:0]};
               end
            end
         end
         ST_START: begin
            r_in     = x_val;
            step_in  = step_ff + ROUND_W'(1);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            step_in = step_ff + ROUND_W'(1);
            if (last_step) begin
               // undo the last swap, whiten the left half
               l_in     = t_val ^ kval;
               state_in = ST_WHITE;
            end else begin
               l_in = r_ff;
               r_in = x_val;
            end
         end
         ST_WHITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (wide_ff) begin
                  out_low_in  = r_fin;
                  out_high_in = l_ff;
               end else begin
                  out_low_in  = {l_ff[WORD_W-1:0], r_fin[WORD_W-1:0]};
                  out_high_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         span_ff      <= '0;
         dec_ff       <= 1'b0;
         wide_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         round_end_ff <= ROUND_END_MAX;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         span_ff      <= span_in;
         dec_ff       <= dec_in;
         wide_ff      <= wide_in;
         rsp_valid_ff <= rsp_valid_in;
         round_end_ff <= round_end_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff        <= l_in;
      r_ff        <= r_in;
      out_low_ff  <= out_low_in;
      out_high_ff <= out_high_in;
   end

   // checks
   a_last_round_to_white: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && last_step) |=> (state_ff == ST_WHITE))
      else $error("last round did not move to whitening");

   a_white_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WHITE) |-> (step_ff == span_ff))
      else $error("whitening step does not match span");

   a_narrow_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && !wide_ff) |-> (l_ff[BLOCK_W-1:WORD_W] == '0 &&
                                              r_ff[BLOCK_W-1:WORD_W] == '0))
      else $error("64-bit mode halves carry upper bits");

   a_rsp_from_white: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_WHITE))
      else $error("response beat raised outside whitening");

   a_round_end_range: assert property (@(posedge clock) disable iff (reset)
      (round_end_ff >= ROUND_END_MIN) && (round_end_ff <= ROUND_END_MAX))
      else $error("round_end out of range");

endmodule
